// ===== src/aabb_cr_pkg.sv =====
package aabb_cr_pkg;

  localparam int POS_W  = 24;
  localparam int SIZE_W = 16;
  // Doubled centre difference 2*(b - a).
  localparam int DIFF_W = POS_W + 2;
  // Sum of two sizes, which is twice the sum of the half sizes.
  localparam int SUM_W  = SIZE_W + 1;
  // Penetration on an overlapping axis is below SUM_W bits in magnitude.
  localparam int PEN_W  = SUM_W + 1;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 104;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] a_x;
    logic signed [POS_W-1:0] a_y;
    logic [SIZE_W-1:0]       a_width;
    logic [SIZE_W-1:0]       a_height;
    logic                    a_fixed;
    logic signed [POS_W-1:0] b_x;
    logic signed [POS_W-1:0] b_y;
    logic [SIZE_W-1:0]       b_width;
    logic [SIZE_W-1:0]       b_height;
    logic                    b_fixed;
  } pair_t;

  // Positions and flags that travel unchanged down the pipeline.
  typedef struct packed {
    logic signed [POS_W-1:0] a_x;
    logic signed [POS_W-1:0] a_y;
    logic                    a_fixed;
    logic signed [POS_W-1:0] b_x;
    logic signed [POS_W-1:0] b_y;
    logic                    b_fixed;
  } pos_t;

  typedef struct packed {
    pos_t                     pos;
    logic signed [DIFF_W-1:0] rx;
    logic signed [DIFF_W-1:0] ry;
    logic [SUM_W-1:0]         sx;
    logic [SUM_W-1:0]         sy;
  } diff_t;

  typedef struct packed {
    pos_t                    pos;
    logic                    hit;
    logic signed [PEN_W-1:0] dx;
    logic signed [PEN_W-1:0] dy;
  } pen_t;

  typedef struct packed {
    pos_t                    pos;
    logic                    hit;
    logic signed [PEN_W-1:0] px;
    logic signed [PEN_W-1:0] py;
  } push_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_b_y;
    logic signed [POS_W-1:0] new_b_x;
    logic signed [POS_W-1:0] new_a_y;
    logic signed [POS_W-1:0] new_a_x;
    logic                    collided;
  } result_t;

endpackage

// ===== src/aabb_cr_diff.sv =====
module aabb_cr_diff (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aabb_cr_pkg::pair_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aabb_cr_pkg::diff_t out_data
);
  import aabb_cr_pkg::*;

  logic  valid_r, valid_nxt;
  diff_t data_r, data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.pos.a_x     = in_data.a_x;
    data_nxt.pos.a_y     = in_data.a_y;
    data_nxt.pos.a_fixed = in_data.a_fixed;
    data_nxt.pos.b_x     = in_data.b_x;
    data_nxt.pos.b_y     = in_data.b_y;
    data_nxt.pos.b_fixed = in_data.b_fixed;
    data_nxt.rx = {({in_data.b_x[POS_W-1], in_data.b_x}
                  - {in_data.a_x[POS_W-1], in_data.a_x}), 1'b0};
    data_nxt.ry = {({in_data.b_y[POS_W-1], in_data.b_y}
                  - {in_data.a_y[POS_W-1], in_data.a_y}), 1'b0};
    data_nxt.sx = {1'b0, in_data.a_width} + {1'b0, in_data.b_width};
    data_nxt.sy = {1'b0, in_data.a_height} + {1'b0, in_data.b_height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/aabb_cr_pen.sv =====
module aabb_cr_pen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aabb_cr_pkg::diff_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aabb_cr_pkg::pen_t  out_data
);
  import aabb_cr_pkg::*;

  localparam int EXT_W = DIFF_W + 1;

  logic                    valid_r, valid_nxt;
  pen_t                    data_r, data_nxt;
  logic signed [EXT_W-1:0] rxe, rye, sxe, sye;
  logic signed [EXT_W-1:0] dx_full, dy_full;
  logic                    ovl_x, ovl_y;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rxe = {in_data.rx[DIFF_W-1], in_data.rx};
    rye = {in_data.ry[DIFF_W-1], in_data.ry};
    sxe = {{(EXT_W-SUM_W){1'b0}}, in_data.sx};
    sye = {{(EXT_W-SUM_W){1'b0}}, in_data.sy};
    // Strict overlap on an axis: -s < r < s.
    ovl_x = ((rxe + sxe) > 0) && ((rxe - sxe) < 0);
    ovl_y = ((rye + sye) > 0) && ((rye - sye) < 0);
    // Equal centres count as B lying on the negative side.
    dx_full = (rxe > 0) ? rxe - sxe : rxe + sxe;
    dy_full = (rye > 0) ? rye - sye : rye + sye;

    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.pos = in_data.pos;
    data_nxt.hit = ovl_x && ovl_y && !(in_data.pos.a_fixed && in_data.pos.b_fixed);
    data_nxt.dx  = dx_full[PEN_W-1:0];
    data_nxt.dy  = dy_full[PEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/aabb_cr_push.sv =====
module aabb_cr_push (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aabb_cr_pkg::pen_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aabb_cr_pkg::push_t out_data
);
  import aabb_cr_pkg::*;

  logic                    valid_r, valid_nxt;
  push_t                   data_r, data_nxt;
  logic [PEN_W-1:0]        mag_x, mag_y;
  logic signed [PEN_W-1:0] sel_x, sel_y;
  logic                    both_move;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    mag_x = in_data.dx[PEN_W-1] ? PEN_W'(-in_data.dx) : PEN_W'(in_data.dx);
    mag_y = in_data.dy[PEN_W-1] ? PEN_W'(-in_data.dy) : PEN_W'(in_data.dy);
    // Keep the shallower axis; a tie resolves along y.
    if (mag_x < mag_y) begin
      sel_x = in_data.dx;
      sel_y = '0;
    end else begin
      sel_x = '0;
      sel_y = in_data.dy;
    end
    both_move = !in_data.pos.a_fixed && !in_data.pos.b_fixed;

    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.pos = in_data.pos;
    data_nxt.hit = in_data.hit;
    // The arithmetic shift floors, which splits the doubled push.
    data_nxt.px  = both_move ? (sel_x >>> 2) : (sel_x >>> 1);
    data_nxt.py  = both_move ? (sel_y >>> 2) : (sel_y >>> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/aabb_cr_apply.sv =====
module aabb_cr_apply (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aabb_cr_pkg::push_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aabb_cr_pkg::result_t out_data
);
  import aabb_cr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  function automatic logic signed [POS_W-1:0] move_sat(
    input logic signed [POS_W-1:0] p,
    input logic signed [PEN_W-1:0] d,
    input logic                    neg
  );
    logic signed [POS_W:0] pe;
    logic signed [POS_W:0] de;
    logic signed [POS_W:0] s;
    pe = {p[POS_W-1], p};
    de = {{(POS_W+1-PEN_W){d[PEN_W-1]}}, d};
    s  = neg ? pe - de : pe + de;
    if (s[POS_W] != s[POS_W-1]) begin
      move_sat = s[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      move_sat = s[POS_W-1:0];
    end
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.collided = in_data.hit;
    data_nxt.new_a_x  = in_data.pos.a_x;
    data_nxt.new_a_y  = in_data.pos.a_y;
    data_nxt.new_b_x  = in_data.pos.b_x;
    data_nxt.new_b_y  = in_data.pos.b_y;
    if (in_data.hit && !in_data.pos.a_fixed) begin
      data_nxt.new_a_x = move_sat(in_data.pos.a_x, in_data.px, 1'b0);
      data_nxt.new_a_y = move_sat(in_data.pos.a_y, in_data.py, 1'b0);
    end
    if (in_data.hit && !in_data.pos.b_fixed) begin
      data_nxt.new_b_x = move_sat(in_data.pos.b_x, in_data.px, 1'b1);
      data_nxt.new_b_y = move_sat(in_data.pos.b_y, in_data.py, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/aabb_collision_resolve.sv =====
// Channel  Direction  Handshake            Word
// in_      slave      in_tvalid/in_tready   in_tdata, 168 bits: one pair of boxes
// out_     master     out_tvalid/out_tready out_tdata, 104 bits: flag and new centres
//
// Each word passes through four register stages: centre differences and size
// sums, overlap test and penetration, axis choice and push split, then the
// saturating position update, which is also the output register.
// out_tvalid rises once a word has passed each stage register in turn; one
// word is taken in every cycle while out_tready stays high.
// Reset (rst_n low, synchronous) empties every stage; no payload is cleared.
// Each stage has its own valid bit and fills whenever it is empty, so a stall
// at the output only stops input once all four stages are full.
module aabb_collision_resolve (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: a_x[24], a_y[24], a_width[16], a_height[16],
  // a_fixed[1], b_x[24], b_y[24], b_width[16], b_height[16], b_fixed[1],
  // then six zero bits.
  input  logic [aabb_cr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: collided[1], new_a_x[24], new_a_y[24],
  // new_b_x[24], new_b_y[24], then seven zero bits.
  output logic [aabb_cr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import aabb_cr_pkg::*;

  pair_t   in_pair;
  diff_t   s1_data;
  pen_t    s2_data;
  push_t   s3_data;
  result_t s4_data;
  logic    s1_valid, s1_ready;
  logic    s2_valid, s2_ready;
  logic    s3_valid, s3_ready;

  // Unpack the input word, first field in the lowest bits.
  assign in_pair.a_x      = in_tdata[23:0];
  assign in_pair.a_y      = in_tdata[47:24];
  assign in_pair.a_width  = in_tdata[63:48];
  assign in_pair.a_height = in_tdata[79:64];
  assign in_pair.a_fixed  = in_tdata[80];
  assign in_pair.b_x      = in_tdata[104:81];
  assign in_pair.b_y      = in_tdata[128:105];
  assign in_pair.b_width  = in_tdata[144:129];
  assign in_pair.b_height = in_tdata[160:145];
  assign in_pair.b_fixed  = in_tdata[161];

  aabb_cr_diff u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_pair),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  aabb_cr_pen u_pen (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  aabb_cr_push u_push (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  aabb_cr_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (s4_data)
  );

  // The result struct is declared from the highest field down, so it packs
  // with collided in bit 0.
  assign out_tdata = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, s4_data};

  // A collision is never reported when both boxes are stationary.
  a_hit_needs_mover: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && s2_data.hit |-> !(s2_data.pos.a_fixed && s2_data.pos.b_fixed))
    else $error("collision flagged for two stationary boxes");

  // The push acts along one axis only.
  a_single_axis: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid && s3_data.hit |-> (s3_data.px == '0) || (s3_data.py == '0))
    else $error("push applied on both axes");

  // A stalled word in the push stage is held, not dropped or overwritten.
  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid && !s3_ready |=> s3_valid && $stable(s3_data))
    else $error("push stage lost a stalled word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import aabb_cr_pkg::*;

  // Generous bound on the whole run; it only catches a hung handshake.
  localparam int CYCLE_LIMIT  = 200000;
  // Length of the long output hold-off, in cycles.
  localparam int HOLD_CYCLES  = 300;
  // Cycles allowed after the last result for stray words to show up.
  localparam int SETTLE_CYCLES = 16;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Resolved positions still owed by the block, oldest first.
  result_t expected_moves[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;

  // Idle rates in per cent for the sending and receiving sides.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // A hold-off is requested by bumping hold_req; the receiver counts it out.
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  aabb_collision_resolve u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input word layout, lowest bits first: box A then box B, six pad bits on top.
  function automatic logic [IN_TDATA_W-1:0] pack_pair(input pair_t p);
    return {6'b0, p.b_fixed, p.b_height, p.b_width, p.b_y, p.b_x,
            p.a_fixed, p.a_height, p.a_width, p.a_y, p.a_x};
  endfunction

  function automatic pair_t make_pair(input int ax, input int ay, input int aw,
                                      input int ah, input bit af, input int bx,
                                      input int by, input int bw, input int bh,
                                      input bit bf);
    pair_t p;
    p.a_x = POS_W'(ax); p.a_y = POS_W'(ay);
    p.a_width = SIZE_W'(aw); p.a_height = SIZE_W'(ah); p.a_fixed = af;
    p.b_x = POS_W'(bx); p.b_y = POS_W'(by);
    p.b_width = SIZE_W'(bw); p.b_height = SIZE_W'(bh); p.b_fixed = bf;
    return p;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  // Works out the pushed centres for one pair. Every coordinate is doubled so
  // that half sizes stay exact; the penetration is then twice the real one.
  function automatic result_t resolve_pair(input pair_t p);
    longint  ax, ay, bx, by, aw, ah, bw, bh;
    longint  rx, ry, dx, dy, px, py, mag_x, mag_y;
    int      shift;
    result_t r;
    ax = longint'($signed(p.a_x));
    ay = longint'($signed(p.a_y));
    bx = longint'($signed(p.b_x));
    by = longint'($signed(p.b_y));
    aw = longint'(p.a_width);
    ah = longint'(p.a_height);
    bw = longint'(p.b_width);
    bh = longint'(p.b_height);
    r.collided = 1'b0;
    r.new_a_x  = p.a_x;
    r.new_a_y  = p.a_y;
    r.new_b_x  = p.b_x;
    r.new_b_y  = p.b_y;
    if (p.a_fixed && p.b_fixed) return r;
    // Strict overlap: touching edges do not count.
    if (!((2 * ax - aw) < (2 * bx + bw) && (2 * ax + aw) > (2 * bx - bw) &&
          (2 * ay - ah) < (2 * by + bh) && (2 * ay + ah) > (2 * by - bh))) begin
      return r;
    end
    rx = 2 * (bx - ax);
    ry = 2 * (by - ay);
    // Equal centres count as B lying on the negative side.
    dx = (rx > 0) ? rx - (aw + bw) : rx + (aw + bw);
    dy = (ry > 0) ? ry - (ah + bh) : ry + (ah + bh);
    mag_x = (dx < 0) ? -dx : dx;
    mag_y = (dy < 0) ? -dy : dy;
    // Only the shallower axis is resolved; a tie goes to y.
    if (mag_x < mag_y) dy = 0;
    else dx = 0;
    // One mover takes the whole push, two movers take half each; the shift
    // rounds towards minus infinity.
    shift = (!p.a_fixed && !p.b_fixed) ? 2 : 1;
    px = dx >>> shift;
    py = dy >>> shift;
    if (!p.a_fixed) begin
      r.new_a_x = clamp_pos(ax + px);
      r.new_a_y = clamp_pos(ay + py);
    end
    if (!p.b_fixed) begin
      r.new_b_x = clamp_pos(bx - px);
      r.new_b_y = clamp_pos(by - py);
    end
    r.collided = 1'b1;
    return r;
  endfunction

  function automatic int random_size();
    if ($urandom_range(99) < 75) return $urandom_range(0, 4095);
    return $urandom_range(0, 65535);
  endfunction

  // Most pairs are placed so that they overlap, touch or just miss; a few sit
  // against the ends of the position range, a few are built to tie, and the
  // rest are raw random words.
  function automatic pair_t random_pair();
    pair_t p;
    int    mode, ax, ay, aw, ah, bw, bh, span_x, span_y, off_x, off_y;
    mode = $urandom_range(99);
    if (mode < 15) begin
      p.a_x = POS_W'($urandom); p.a_y = POS_W'($urandom);
      p.a_width = SIZE_W'($urandom); p.a_height = SIZE_W'($urandom);
      p.a_fixed = 1'($urandom);
      p.b_x = POS_W'($urandom); p.b_y = POS_W'($urandom);
      p.b_width = SIZE_W'($urandom); p.b_height = SIZE_W'($urandom);
      p.b_fixed = 1'($urandom);
      return p;
    end
    aw = random_size(); ah = random_size();
    bw = random_size(); bh = random_size();
    if (mode < 27) begin
      ax = ($urandom_range(1)) ? 8388607 - $urandom_range(0, 70000)
                               : -8388608 + $urandom_range(0, 70000);
      ay = ($urandom_range(1)) ? 8388607 - $urandom_range(0, 70000)
                               : -8388608 + $urandom_range(0, 70000);
    end else begin
      ax = $signed(POS_W'($urandom));
      ay = $signed(POS_W'($urandom));
    end
    if (mode >= 27 && mode < 37) begin
      // Same sizes and offsets on both axes give equal penetrations.
      ah = aw; bh = bw;
    end
    span_x = aw + bw + 4;
    span_y = ah + bh + 4;
    off_x  = $urandom_range(0, span_x) - span_x / 2;
    off_y  = (mode >= 27 && mode < 37) ? off_x : $urandom_range(0, span_y) - span_y / 2;
    // Sizes are full widths, so half the span is the reach from centre to edge.
    off_x  = off_x / 2 + (off_x % 2);
    off_y  = off_y / 2 + (off_y % 2);
    if (mode >= 27 && mode < 37) off_y = off_x;
    p = make_pair(ax, ay, aw, ah, 1'($urandom_range(1)), ax + off_x, ay + off_y, bw, bh,
                  1'($urandom_range(1)));
    return p;
  endfunction

  // Offers one word, waits for it to be taken and records what it must give.
  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_pair(p);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_moves.push_back(resolve_pair(p));
  endtask

  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Both boxes stationary and overlapping: nothing moves.
    send_pair(make_pair(0, 0, 512, 512, 1, 100, 50, 512, 512, 1));
    // Clearly apart.
    send_pair(make_pair(0, 0, 256, 256, 0, 1000, 0, 256, 256, 0));
    // Edges touching on x, then on y: no overlap either way.
    send_pair(make_pair(0, 0, 256, 256, 0, 256, 0, 256, 256, 0));
    send_pair(make_pair(0, 0, 256, 256, 0, 0, -256, 256, 256, 0));
    // Shallower on x, both movable.
    send_pair(make_pair(0, 0, 512, 512, 0, 100, 20, 512, 512, 0));
    // Equal penetrations with only A movable: the push goes on y.
    send_pair(make_pair(1000, 2000, 300, 700, 0, 1100, 1900, 500, 100, 1));
    // Only B moves.
    send_pair(make_pair(-5000, -5000, 1000, 1000, 1, -4900, -5300, 800, 900, 0));
    // Equal penetrations: the push goes on y.
    send_pair(make_pair(0, 0, 512, 512, 0, 100, 100, 512, 512, 0));
    // Equal centres on both axes.
    send_pair(make_pair(300, -300, 400, 200, 0, 300, -300, 100, 600, 0));
    // Zero-size A inside B, then two zero-size boxes at one point.
    send_pair(make_pair(10, 10, 0, 0, 0, 0, 0, 256, 256, 0));
    send_pair(make_pair(7, 7, 0, 0, 0, 7, 7, 0, 0, 0));
    // A pushed past the top and the bottom of the range.
    send_pair(make_pair(8388607, 0, 65535, 65535, 0, 8388591, 0, 65535, 65535, 1));
    send_pair(make_pair(-8388608, 0, 65535, 65535, 0, -8388592, 0, 65535, 65535, 1));
    // B pushed past the top of the range on y.
    send_pair(make_pair(0, 8388600, 65535, 65535, 1, 0, 8388607, 65535, 65535, 0));
    // Opposite corners of the range, first with full sizes, then with zero sizes.
    send_pair(make_pair(8388607, 8388607, 65535, 65535, 0,
                        -8388608, -8388608, 65535, 65535, 0));
    send_pair(make_pair(-8388608, -8388608, 0, 0, 1, 8388607, 8388607, 0, 0, 0));
    // Odd penetrations: rounding of a negative quarter and a positive half.
    send_pair(make_pair(0, 0, 3, 3, 0, 1, 0, 2, 2, 0));
    send_pair(make_pair(0, 0, 3, 3, 0, -1, 0, 2, 2, 1));
    // Largest boxes on the same centre.
    send_pair(make_pair(0, 0, 65535, 65535, 0, 0, 0, 65535, 65535, 0));
    send_pair(make_pair(-100000, -100000, 2000, 800, 1, -100500, -99900, 2000, 800, 0));
    send_pair(make_pair(-1, -1, 65535, 65535, 1, -1, -1, 65535, 65535, 1));
    wait_until_drained();
  endtask

  task automatic test_random_pairs(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // all four stages fill and the input has to stall.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (40) send_pair(random_pair());
  endtask

  // The sender stops until every result is back, then carries on.
  task automatic test_pause_until_drained();
    send_idle_pct = 6;
    recv_idle_pct = 46;
    repeat (15) send_pair(random_pair());
    wait_until_drained();
    repeat (15) send_pair(random_pair());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_pairs(290, 6, 46);
    test_random_pairs(290, 46, 6);
    test_random_pairs(250, 0, 0);
    test_output_hold_off();
    test_pause_until_drained();
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each word taken from the output is checked against the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_moves.pop_front();
        compare_field("collided", POS_W'(want.collided), POS_W'(got.collided));
        compare_field("new_a_x", want.new_a_x, got.new_a_x);
        compare_field("new_a_y", want.new_a_y, got.new_a_y);
        compare_field("new_b_x", want.new_b_x, got.new_b_x);
        compare_field("new_b_y", want.new_b_y, got.new_b_y);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
